FILE: hw/rtl/limit_order_matching_engine_core_assert.svh
// Assertion macros for the order book engine.
`ifndef LIMIT_ORDER_MATCHING_ENGINE_CORE_ASSERT_SVH
`define LIMIT_ORDER_MATCHING_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LOME_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define LOME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/lome_pkg.sv
// Shared codes for the order book engine.
package lome_pkg;
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_MODIFY = 2'd2;

  localparam logic [2:0] KIND_TRADE    = 3'd0;
  localparam logic [2:0] KIND_DONE     = 3'd1;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd2;
  localparam logic [2:0] KIND_FULL     = 3'd3;
  localparam logic [2:0] KIND_DUP      = 3'd4;
endpackage

FILE: hw/rtl/limit_order_matching_engine_core.sv
// Price-time priority limit order book with matching engine.
//
// A request (add, cancel, modify) is taken when start_i is high and busy_o is
// low. busy_o stays high until the request's last result has been launched.
// Results appear for exactly one cycle with strobe_o high; the receiver must
// take them, there is no back-pressure. Every request ends with one status
// item carrying last_o = 1; trades before it carry last_o = 0.
// Structure: all work goes through one slot-read/compare datapath stepped by a
// small sequencer, one book slot per cycle. An id lookup scan over every slot
// is followed by a decision state. Each best-price search is another full scan
// followed by a decision state and then a trade or rest state; after each trade
// the search runs again until the order is filled or nothing crosses. Cancel,
// unknown ids, duplicates and zero quantity finish after the lookup scan.
// Time priority: older arrival stamp wins at equal price, then lower slot.
module limit_order_matching_engine_core #(
  parameter int ORDER_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] order_id_i,
  input  logic        side_i,
  input  logic [31:0] price_i,
  input  logic [31:0] quantity_i,
  output logic        strobe_o,
  output logic [2:0]  kind_o,
  output logic [31:0] buyer_id_o,
  output logic [31:0] seller_id_o,
  output logic [31:0] trade_price_o,
  output logic [31:0] amount_o,
  output logic        last_o
);
  import lome_pkg::*;
  `include "limit_order_matching_engine_core_assert.svh"

  localparam int IW = $clog2(ORDER_SLOTS);
  localparam int CW = $clog2(ORDER_SLOTS + 1);
  localparam logic [CW-1:0] LAST_SLOT = CW'(ORDER_SLOTS - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1; // id lookup scan
  localparam logic [2:0] S_DECIDE = 3'd2; // act on lookup
  localparam logic [2:0] S_MATCH  = 3'd3; // best-cross scan + free slot
  localparam logic [2:0] S_MDEC   = 3'd4;
  localparam logic [2:0] S_TRADE  = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6; // fully filled: done 0
  localparam logic [2:0] S_REST   = 3'd7; // rest remainder or drop

  // book storage
  logic [ORDER_SLOTS-1:0] valid_q;
  logic        sell_mem  [ORDER_SLOTS];
  logic [31:0] px_mem    [ORDER_SLOTS];
  logic [31:0] qty_mem   [ORDER_SLOTS];
  logic [31:0] tag_mem   [ORDER_SLOTS];
  logic [31:0] arr_mem   [ORDER_SLOTS];

  logic [2:0]    state_q;
  logic [CW-1:0] scan_q;
  logic          found_q, free_found_q, best_ok_q, strobe_q;
  logic [IW-1:0] tgt_q, free_q, best_q;
  logic [31:0]   arr_q;

  // latched request and working values
  logic [1:0]  act_q;
  logic [31:0] tag_q, px_q, qty_q, left_q, best_px_q, best_age_q;
  logic        side_q;

  logic [2:0]  kind_q;
  logic [31:0] buyer_q, seller_q, tpx_q, amt_q;
  logic        last_q;

  // single shared read port and compare datapath
  logic [IW-1:0] rd_idx;
  logic          r_valid, r_sell, cand, better, last_scan;
  logic [31:0]   r_px, r_qty, r_tag, r_arr, age, q_fill;

  always_comb begin
    case (state_q)
      S_DECIDE: rd_idx = tgt_q;
      S_TRADE:  rd_idx = best_q;
      default:  rd_idx = scan_q[IW-1:0];
    endcase
  end

  assign r_valid   = valid_q[rd_idx];
  assign r_sell    = sell_mem[rd_idx];
  assign r_px      = px_mem[rd_idx];
  assign r_qty     = qty_mem[rd_idx];
  assign r_tag     = tag_mem[rd_idx];
  assign r_arr     = arr_mem[rd_idx];
  assign age       = arr_q - r_arr;
  assign last_scan = (scan_q == LAST_SLOT);
  assign q_fill    = (left_q < r_qty) ? left_q : r_qty;

  // resting order on the opposite side whose price crosses ours
  assign cand = r_valid && (r_sell != side_q) &&
                (side_q ? (r_px >= px_q) : (r_px <= px_q));
  assign better = !best_ok_q ||
                  ((r_px == best_px_q) ? (age > best_age_q) :
                   (side_q ? (r_px > best_px_q) : (r_px < best_px_q)));

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scan_q       <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      best_ok_q    <= 1'b0;
      strobe_q     <= 1'b0;
      tgt_q        <= '0;
      free_q       <= '0;
      best_q       <= '0;
      arr_q        <= '0;
      valid_q      <= '0;
    end else begin
      strobe_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_FIND;
            scan_q  <= '0;
            found_q <= 1'b0;
          end
        end
        S_FIND: begin
          if (r_valid && (r_tag == tag_q) && !found_q) begin
            found_q <= 1'b1;
            tgt_q   <= rd_idx;
          end
          if (last_scan) begin
            state_q <= S_DECIDE;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_DECIDE: begin
          state_q  <= S_IDLE;
          strobe_q <= 1'b1;
          scan_q       <= '0;
          best_ok_q    <= 1'b0;
          free_found_q <= 1'b0;
          case (act_q)
            ACT_ADD: begin
              if (!found_q) begin
                arr_q <= arr_q + 1'b1;
                if (qty_q != '0) begin
                  state_q  <= S_MATCH;
                  strobe_q <= 1'b0;
                end
              end
            end
            ACT_CANCEL, ACT_MODIFY: begin
              if (found_q) begin
                valid_q[tgt_q] <= 1'b0;
                if ((act_q == ACT_MODIFY) && (qty_q != '0)) begin
                  arr_q    <= arr_q + 1'b1;
                  state_q  <= S_MATCH;
                  strobe_q <= 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
        S_MATCH: begin
          if (!r_valid && !free_found_q) begin
            free_found_q <= 1'b1;
            free_q       <= rd_idx;
          end
          if (cand && better) begin
            best_ok_q <= 1'b1;
            best_q    <= rd_idx;
          end
          if (last_scan) begin
            state_q <= S_MDEC;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_MDEC: begin
          state_q <= best_ok_q ? S_TRADE : S_REST;
        end
        S_TRADE: begin
          strobe_q <= 1'b1;
          if (q_fill == r_qty) begin
            valid_q[best_q] <= 1'b0;
          end
          scan_q       <= '0;
          best_ok_q    <= 1'b0;
          free_found_q <= 1'b0;
          state_q      <= (left_q == q_fill) ? S_FIN : S_MATCH;
        end
        S_FIN: begin
          strobe_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        S_REST: begin
          strobe_q <= 1'b1;
          state_q  <= S_IDLE;
          if (free_found_q) begin
            valid_q[free_q] <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload, working values and book contents
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_q  <= action_i;
          tag_q  <= order_id_i;
          side_q <= side_i;
          px_q   <= price_i;
          qty_q  <= quantity_i;
        end
      end
      S_DECIDE: begin
        left_q   <= qty_q;
        buyer_q  <= '0;
        seller_q <= '0;
        tpx_q    <= '0;
        last_q   <= 1'b1;
        kind_q   <= KIND_DONE;
        amt_q    <= '0;
        case (act_q)
          ACT_ADD: begin
            if (found_q) begin
              kind_q <= KIND_DUP;
              amt_q  <= qty_q;
            end
          end
          ACT_CANCEL, ACT_MODIFY: begin
            if (!found_q) begin
              kind_q <= KIND_NOT_FOUND;
            end else begin
              amt_q  <= r_qty;
              side_q <= r_sell;
            end
          end
          default: ;
        endcase
      end
      S_MATCH: begin
        if (cand && better) begin
          best_px_q  <= r_px;
          best_age_q <= age;
        end
      end
      S_TRADE: begin
        kind_q   <= KIND_TRADE;
        buyer_q  <= side_q ? r_tag : tag_q;
        seller_q <= side_q ? tag_q : r_tag;
        tpx_q    <= r_px;
        amt_q    <= q_fill;
        last_q   <= 1'b0;
        left_q   <= left_q - q_fill;
        qty_mem[best_q] <= r_qty - q_fill;
      end
      S_FIN: begin
        kind_q   <= KIND_DONE;
        buyer_q  <= '0;
        seller_q <= '0;
        tpx_q    <= '0;
        amt_q    <= '0;
        last_q   <= 1'b1;
      end
      S_REST: begin
        kind_q   <= free_found_q ? KIND_DONE : KIND_FULL;
        buyer_q  <= '0;
        seller_q <= '0;
        tpx_q    <= '0;
        amt_q    <= left_q;
        last_q   <= 1'b1;
        if (free_found_q) begin
          sell_mem[free_q] <= side_q;
          px_mem[free_q]   <= px_q;
          qty_mem[free_q]  <= left_q;
          tag_mem[free_q]  <= tag_q;
          arr_mem[free_q]  <= arr_q;
        end
      end
      default: ;
    endcase
  end

  assign busy_o        = (state_q != S_IDLE);
  assign strobe_o      = strobe_q;
  assign kind_o        = kind_q;
  assign buyer_id_o    = buyer_q;
  assign seller_id_o   = seller_q;
  assign trade_price_o = tpx_q;
  assign amount_o      = amt_q;
  assign last_o        = last_q;

  `LOME_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  `LOME_ASSERT_NOW(a_trade_not_last, strobe_o && (kind_o == KIND_TRADE), !last_o)
  `LOME_ASSERT_NEXT(a_trade_needs_best, state_q == S_MDEC && !best_ok_q, state_q == S_REST)
  `LOME_ASSERT_NOW(a_idle_status_last, strobe_o && !busy_o, last_o)
endmodule

FILE: sim/limit_order_matching_engine_core_tb.sv
// Self-checking testbench for the limit order matching engine core.
module limit_order_matching_engine_core_tb;
  import lome_pkg::*;

  localparam int SLOTS = 32;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] buyer;
    logic [31:0] seller;
    logic [31:0] px;
    logic [31:0] amt;
    logic        last;
  } book_event_t;

  // Book shadow plus the queue of events the block still owes us.
  class book_scoreboard;
    bit          live[SLOTS];
    bit          is_sell[SLOTS];
    logic [31:0] px[SLOTS];
    logic [31:0] qty[SLOTS];
    logic [31:0] tag[SLOTS];
    logic [31:0] stamp[SLOTS];
    logic [31:0] clock_stamp = '0;
    book_event_t owed[$];
    int          errors;
    int          events_seen;
    int          trades_seen;
    int          fulls_seen;

    function void post(logic [2:0] k, logic [31:0] b, logic [31:0] s,
                       logic [31:0] p, logic [31:0] a, logic l);
      book_event_t e;
      e.kind = k; e.buyer = b; e.seller = s; e.px = p; e.amt = a; e.last = l;
      owed.insert(owed.size(), e);
    endfunction

    function int lookup(logic [31:0] id);
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && tag[i] == id) return i;
      return -1;
    endfunction

    // Best crossing resting order: price first, then age, then lowest slot.
    function int best_contra(bit sell, logic [31:0] limit);
      int best;
      logic [31:0] age, best_age;
      bit better;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!live[i] || is_sell[i] == sell) continue;
        if (sell ? (px[i] < limit) : (px[i] > limit)) continue;
        if (best < 0) begin
          best = i;
          continue;
        end
        age = clock_stamp - stamp[i];
        best_age = clock_stamp - stamp[best];
        if (px[i] == px[best]) better = age > best_age;
        else if (sell) better = px[i] > px[best];
        else better = px[i] < px[best];
        if (better) best = i;
      end
      return best;
    endfunction

    function void match_and_rest(logic [31:0] id, bit sell, logic [31:0] limit,
                                 logic [31:0] want);
      logic [31:0] left, q;
      int b;
      left = want;
      clock_stamp = clock_stamp + 1;
      while (left != 0) begin
        b = best_contra(sell, limit);
        if (b < 0) break;
        q = (left < qty[b]) ? left : qty[b];
        if (sell) post(KIND_TRADE, tag[b], id, px[b], q, 1'b0);
        else post(KIND_TRADE, id, tag[b], px[b], q, 1'b0);
        left -= q;
        qty[b] -= q;
        if (qty[b] == 0) live[b] = 0;
      end
      if (left == 0) begin
        post(KIND_DONE, 0, 0, 0, 0, 1'b1);
        return;
      end
      for (int i = 0; i < SLOTS; i++)
        if (!live[i]) begin
          live[i] = 1; is_sell[i] = sell; px[i] = limit; qty[i] = left;
          tag[i] = id; stamp[i] = clock_stamp;
          post(KIND_DONE, 0, 0, 0, left, 1'b1);
          return;
        end
      post(KIND_FULL, 0, 0, 0, left, 1'b1);
    endfunction

    // Called for every accepted request.
    function void note_request(logic [1:0] act, logic [31:0] id, logic side,
                               logic [31:0] limit, logic [31:0] want);
      int k;
      logic [31:0] old;
      if (act == ACT_ADD) begin
        if (lookup(id) >= 0) post(KIND_DUP, 0, 0, 0, want, 1'b1);
        else match_and_rest(id, side, limit, want);
      end else if (act == ACT_CANCEL || act == ACT_MODIFY) begin
        k = lookup(id);
        if (k < 0) begin
          post(KIND_NOT_FOUND, 0, 0, 0, 0, 1'b1);
          return;
        end
        old = qty[k];
        live[k] = 0;
        if (act == ACT_CANCEL || want == 0) post(KIND_DONE, 0, 0, 0, old, 1'b1);
        else match_and_rest(id, is_sell[k], limit, want);
      end else begin
        post(KIND_DONE, 0, 0, 0, 0, 1'b1);
      end
    endfunction

    function void flag(string what, book_event_t exp_e, book_event_t got);
      errors++;
      if (errors <= 10) begin
        $display("MISMATCH %s: exp kind=%0d b=%0d s=%0d px=%0d amt=%0d last=%0d",
                 what, exp_e.kind, exp_e.buyer, exp_e.seller, exp_e.px, exp_e.amt,
                 exp_e.last);
        $display("  got kind=%0d b=%0d s=%0d px=%0d amt=%0d last=%0d",
                 got.kind, got.buyer, got.seller, got.px, got.amt, got.last);
      end
    endfunction

    function void check_event(book_event_t got);
      book_event_t e;
      events_seen++;
      if (got.kind == KIND_TRADE) trades_seen++;
      if (got.kind == KIND_FULL) fulls_seen++;
      if (owed.size() == 0) begin
        flag("unexpected", '0, got);
        return;
      end
      e = owed.pop_front();
      if (e !== got) flag("field", e, got);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  action_i = '0;
  logic [31:0] order_id_i = '0;
  logic        side_i = 1'b0;
  logic [31:0] price_i = '0;
  logic [31:0] quantity_i = '0;
  logic        busy_o, strobe_o, last_o;
  logic [2:0]  kind_o;
  logic [31:0] buyer_id_o, seller_id_o, trade_price_o, amount_o;

  book_scoreboard sb = new();
  int cycles = 0;
  int idle_pct = 0;
  int requests = 0;

  always #6 clk_i = ~clk_i;

  limit_order_matching_engine_core #(.ORDER_SLOTS(SLOTS)) dut (.*);

  // Monitor: results first, so a last result and the next request taken on
  // the same edge stay in order. Active-region reads see pre-edge values.
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && strobe_o)
      sb.check_event({kind_o, buyer_id_o, seller_id_o, trade_price_o, amount_o, last_o});
    if (rst_ni && start_i && !busy_o) begin
      sb.note_request(action_i, order_id_i, side_i, price_i, quantity_i);
      requests++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("limit_order_matching_engine_core_tb: errors");
      $finish;
    end
  end

  // One request: optional idle gap, then hold start until the block takes it.
  task automatic send_request(logic [1:0] act, logic [31:0] id, logic side,
                              logic [31:0] limit, logic [31:0] want);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    action_i <= act; order_id_i <= id; side_i <= side;
    price_i <= limit; quantity_i <= want; start_i <= 1'b1;
    do @(posedge clk_i); while (!(start_i && !busy_o));
  endtask

  // Hold off until the block has delivered everything owed.
  task automatic drain_book;
    start_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  // Mostly a small id pool so cancels, modifies and duplicates hit; some wide.
  function automatic logic [31:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 88) return $urandom_range(40, 1);
    if (r < 92) return 32'h0;
    if (r < 95) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Buys sit a bit below sells, with overlap so some cross.
  function automatic logic [31:0] pick_price(logic side);
    int r;
    r = $urandom_range(99);
    if (r < 3) return 32'h0;
    if (r < 6) return 32'hFFFF_FFFF;
    if (r < 8) return $urandom;
    return side ? $urandom_range(125, 100) : $urandom_range(110, 85);
  endfunction

  function automatic logic [31:0] pick_qty();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'h0;
    if (r < 8) return $urandom;
    if (r < 10) return 32'hFFFF_FFFF;
    return $urandom_range(60, 1);
  endfunction

  task automatic random_request;
    int r;
    logic s;
    r = $urandom_range(99);
    s = $urandom_range(1);
    if (r < 60) send_request(ACT_ADD, pick_id(), s, pick_price(s), pick_qty());
    else if (r < 76) send_request(ACT_CANCEL, pick_id(), s, $urandom, $urandom);
    else if (r < 97) send_request(ACT_MODIFY, pick_id(), s, pick_price(s), pick_qty());
    else send_request(ACT_UNKNOWN, $urandom, s, $urandom, $urandom);
  endtask

  initial begin
    int phase_pct[4];
    phase_pct = '{0, 59, 0, 31};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: crossing both ways, price then time priority, extremes.
    send_request(ACT_ADD, 32'd1, 1'b1, 32'd100, 32'd10);
    send_request(ACT_ADD, 32'd2, 1'b1, 32'd100, 32'd5);
    send_request(ACT_ADD, 32'd3, 1'b1, 32'd99, 32'd4);
    send_request(ACT_ADD, 32'd4, 1'b0, 32'd100, 32'd16);      // three trades
    send_request(ACT_ADD, 32'd5, 1'b0, 32'd98, 32'd7);
    send_request(ACT_ADD, 32'd6, 1'b1, 32'd0, 32'd20);        // sweeps bids
    send_request(ACT_ADD, 32'd6, 1'b0, 32'd50, 32'd3);        // duplicate id
    send_request(ACT_ADD, 32'd7, 1'b0, 32'd50, 32'd0);        // zero quantity
    send_request(ACT_CANCEL, 32'd6, 1'b0, 32'd0, 32'd0);
    send_request(ACT_CANCEL, 32'd6, 1'b0, 32'd0, 32'd0);      // now unknown
    send_request(ACT_MODIFY, 32'd99, 1'b0, 32'd1, 32'd1);     // unknown id
    send_request(ACT_ADD, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_ADD, 32'h0, 1'b0, 32'hFFFF_FFFE, 32'd8);
    send_request(ACT_MODIFY, 32'h0, 1'b1, 32'd5, 32'd3);      // keeps buy side
    send_request(ACT_MODIFY, 32'hFFFF_FFFF, 1'b1, 32'd7, 32'd0); // acts as cancel
    send_request(ACT_ADD, 32'd8, 1'b1, 32'd0, 32'hFFFF_FFFF); // hits the bid
    send_request(ACT_UNKNOWN, 32'hA5A5_5A5A, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_CANCEL, 32'd8, 1'b0, 32'd0, 32'd0);
    drain_book();

    // Fill the book with non-crossing bids, overflow it, then clear it.
    for (int i = 0; i < SLOTS + 2; i++)
      send_request(ACT_ADD, 32'd1000 + i, 1'b0, $urandom_range(20, 10),
                   $urandom_range(9, 1));
    send_request(ACT_ADD, 32'd2000, 1'b1, 32'd15, 32'd40);
    for (int i = 0; i < SLOTS; i++)
      send_request(ACT_CANCEL, 32'd1000 + i, 1'b0, 32'd0, 32'd0);
    drain_book();

    // Random traffic in idle phases; pause for a full drain between them.
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      repeat (70) random_request();
      drain_book();
    end
    idle_pct = 0;

    start_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (sb.owed.size() != 0) sb.errors += sb.owed.size();

    $display("covered %0d requests, %0d result events, %0d trades, %0d book-full drops",
             requests, sb.events_seen, sb.trades_seen, sb.fulls_seen);
    $display("idle phases 0/59/0/31 percent, mismatches %0d", sb.errors);
    if (sb.errors == 0)
      $display("limit_order_matching_engine_core_tb: clean");
    else
      $display("limit_order_matching_engine_core_tb: errors");
    $finish;
  end
endmodule
